FILE: src/lru_slot_replacement_unit_defines.svh
// assertion macros shared by the checker of the lru slot replacement unit
`ifndef LRU_SLOT_REPLACEMENT_UNIT_DEFINES_SVH
`define LRU_SLOT_REPLACEMENT_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define LRU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lru_pkg.sv
// shared constants for the lru slot replacement unit
package lru_pkg;

    localparam int SLOT_COUNT_DEF = 4;
    localparam int TAG_WIDTH_DEF  = 16;
    localparam int BIN_W          = 16;
    localparam int SLOT_IDX_W     = 2;

endpackage

FILE: src/lru_tag_store.sv
// slot tags, valid bits, fill count and parallel tag match
module lru_tag_store #(
    parameter int SLOT_COUNT = lru_pkg::SLOT_COUNT_DEF,
    parameter int TAG_WIDTH  = lru_pkg::TAG_WIDTH_DEF,
    localparam int IDX_W     = $clog2(SLOT_COUNT),
    localparam int CNT_W     = $clog2(SLOT_COUNT + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [TAG_WIDTH-1:0] lookup_tag,
    output logic                 match,
    output logic [IDX_W-1:0]     match_slot,
    output logic                 full,
    output logic [IDX_W-1:0]     fill_slot,
    output logic [CNT_W-1:0]     filled,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_slot,
    input  logic [TAG_WIDTH-1:0] wr_tag,
    input  logic [IDX_W-1:0]     rd_slot,
    output logic [TAG_WIDTH-1:0] rd_tag
);
    import lru_pkg::*;

    logic [TAG_WIDTH-1:0]  tag_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_COUNT-1:0] valid_next;
    logic [CNT_W-1:0]      filled_reg;
    logic [CNT_W-1:0]      filled_next;

    assign full      = (filled_reg == CNT_W'(SLOT_COUNT));
    assign fill_slot = filled_reg[IDX_W-1:0];
    assign filled    = filled_reg;
    assign rd_tag    = tag_reg[rd_slot];

    // lowest matching slot wins
    always_comb
    begin
        match      = 1'b0;
        match_slot = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (tag_reg[i] == lookup_tag))
            begin
                match      = 1'b1;
                match_slot = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        filled_next = filled_reg;
        if (wr_en)
        begin
            valid_next[wr_slot] = 1'b1;
            if (!full)
            begin
                filled_next = filled_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            filled_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_reg[wr_slot] <= wr_tag;
        end
    end

endmodule

FILE: src/lru_order_list.sv
// recency list of slot numbers, most recent at position zero
module lru_order_list #(
    parameter int SLOT_COUNT = lru_pkg::SLOT_COUNT_DEF,
    localparam int IDX_W     = $clog2(SLOT_COUNT),
    localparam int CNT_W     = $clog2(SLOT_COUNT + 1)
) (
    input  logic             clk,
    input  logic [IDX_W-1:0] lookup_slot,
    input  logic [CNT_W-1:0] filled,
    output logic [IDX_W-1:0] lookup_pos,
    output logic [IDX_W-1:0] lru_slot,
    input  logic             upd_en,
    input  logic [IDX_W-1:0] upd_pos,
    input  logic [IDX_W-1:0] upd_slot
);
    import lru_pkg::*;

    logic [IDX_W-1:0] order_reg [SLOT_COUNT];

    assign lru_slot = order_reg[SLOT_COUNT-1];

    // only filled positions are meaningful
    always_comb
    begin
        lookup_pos = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < filled) && (order_reg[i] == lookup_slot))
            begin
                lookup_pos = IDX_W'(i);
            end
        end
    end

    // entries before upd_pos move down one, chosen slot goes to the front
    always_ff @(posedge clk)
    begin
        if (upd_en)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (i == 0)
                begin
                    order_reg[i] <= upd_slot;
                end
                else if (IDX_W'(i) <= upd_pos)
                begin
                    order_reg[i] <= order_reg[i-1];
                end
            end
        end
    end

endmodule

FILE: src/lru_slot_replacement_unit.sv
// lru slot replacement unit: one request in, hit or fill or eviction result out
// a request passes the input register, then the result register, before its result is valid
// throughput: one request per cycle while the result is not stalled, tag match and recency update in the same cycle
// a stalled result holds the stage behind it; one more request can wait in the input register
// reset clears valid bits, fill count and both stage valids; tags and order need no clearing
module lru_slot_replacement_unit #(
    parameter int SLOT_COUNT = lru_pkg::SLOT_COUNT_DEF,
    parameter int TAG_WIDTH  = lru_pkg::TAG_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lru_pkg::BIN_W-1:0]    requested_bin,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic [lru_pkg::SLOT_IDX_W-1:0] slot_index,
    output logic                         evicted_valid,
    output logic [lru_pkg::BIN_W-1:0]    evicted_bin
);
    import lru_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    logic                  req_valid_reg;
    logic                  req_valid_next;
    logic [TAG_WIDTH-1:0]  req_tag_reg;
    logic [TAG_WIDTH+BIN_W-1:0] bin_ext;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  hit_reg;
    logic [SLOT_IDX_W-1:0] slot_reg;
    logic                  ev_valid_reg;
    logic [BIN_W-1:0]      ev_bin_reg;

    logic                  advance;
    logic                  match;
    logic [IDX_W-1:0]      match_slot;
    logic                  full;
    logic [IDX_W-1:0]      fill_slot;
    logic [CNT_W-1:0]      filled;
    logic [IDX_W-1:0]      lookup_pos;
    logic [IDX_W-1:0]      lru_slot;
    logic [TAG_WIDTH-1:0]  rd_tag;
    logic                  evict;
    logic [IDX_W-1:0]      slot_sel;
    logic [IDX_W-1:0]      pos_sel;
    logic [IDX_W+SLOT_IDX_W-1:0] slot_ext;
    logic [TAG_WIDTH+BIN_W-1:0]  ev_ext;

    assign advance  = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;
    assign bin_ext  = {{TAG_WIDTH{1'b0}}, requested_bin};

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_valid && in_ready)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_tag_reg <= bin_ext[TAG_WIDTH-1:0];
        end
    end

    lru_tag_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .TAG_WIDTH  (TAG_WIDTH)
    ) u_tag_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_tag (req_tag_reg),
        .match      (match),
        .match_slot (match_slot),
        .full       (full),
        .fill_slot  (fill_slot),
        .filled     (filled),
        .wr_en      (advance && !match),
        .wr_slot    (slot_sel),
        .wr_tag     (req_tag_reg),
        .rd_slot    (lru_slot),
        .rd_tag     (rd_tag)
    );

    lru_order_list #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_order_list (
        .clk         (clk),
        .lookup_slot (match_slot),
        .filled      (filled),
        .lookup_pos  (lookup_pos),
        .lru_slot    (lru_slot),
        .upd_en      (advance),
        .upd_pos     (pos_sel),
        .upd_slot    (slot_sel)
    );

    // hit keeps its slot, fill takes the next free one, eviction reuses the oldest
    assign evict = !match && full;

    always_comb
    begin
        if (match)
        begin
            slot_sel = match_slot;
            pos_sel  = lookup_pos;
        end
        else if (full)
        begin
            slot_sel = lru_slot;
            pos_sel  = IDX_W'(SLOT_COUNT - 1);
        end
        else
        begin
            slot_sel = fill_slot;
            pos_sel  = fill_slot;
        end
    end

    assign slot_ext = {{SLOT_IDX_W{1'b0}}, slot_sel};
    assign ev_ext   = {{BIN_W{1'b0}}, rd_tag};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg      <= match;
            slot_reg     <= slot_ext[SLOT_IDX_W-1:0];
            ev_valid_reg <= evict;
            ev_bin_reg   <= evict ? ev_ext[BIN_W-1:0] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign slot_index    = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_bin   = ev_bin_reg;

endmodule

FILE: src/lru_checker.sv
// port-level checker for the lru slot replacement unit and its bind
`include "lru_slot_replacement_unit_defines.svh"

module lru_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           hit,
    input logic [lru_pkg::SLOT_IDX_W-1:0] slot_index,
    input logic                           evicted_valid,
    input logic [lru_pkg::BIN_W-1:0]      evicted_bin
);
    import lru_pkg::*;

    // a hit never evicts
    `LRU_ASSERT_SAME(a_hit_no_evict, out_valid && hit, !evicted_valid, "hit with eviction")

    // evicted identifier is zero unless an eviction happened
    `LRU_ASSERT_SAME(a_ev_bin_zero, out_valid && !evicted_valid, evicted_bin == '0,
        "evicted_bin not zero without eviction")

    // input only backs up behind a stalled result
    `LRU_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready,
        "input stalled without a stalled result")

    // stalled result holds
    `LRU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(hit) && $stable(slot_index) && $stable(evicted_valid)
            && $stable(evicted_bin), "stalled result changed")

endmodule

bind lru_slot_replacement_unit lru_checker u_lru_checker (.*);

FILE: bench/lru_replacement_checker.sv
// checker for the lru slot replacement unit: recency predictor and result scoreboard
module lru_replacement_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [lru_pkg::BIN_W-1:0]       requested_bin,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            hit,
    input  logic [lru_pkg::SLOT_IDX_W-1:0]  slot_index,
    input  logic                            evicted_valid,
    input  logic [lru_pkg::BIN_W-1:0]       evicted_bin,
    output int                              mismatch_count,
    output int                              pending_count,
    output int                              result_count,
    output int                              hit_count,
    output int                              eviction_count
);
    import lru_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  ev_valid;
        logic [BIN_W-1:0]      ev_bin;
    } slot_result_t;

    // predicted contents of the store
    logic [TAG_WIDTH_DEF-1:0] stored_tag [SLOTS];
    logic                     tag_valid  [SLOTS];
    logic [SLOT_IDX_W-1:0]    recency    [SLOTS];
    int                       filled;

    slot_result_t expected_results [$];
    slot_result_t want;
    slot_result_t got;

    // move the entry at recency position pos to the front
    function automatic void promote(input int pos);
        logic [SLOT_IDX_W-1:0] moved;
        moved = recency[pos];
        for (int i = pos; i > 0; i--)
            recency[i] = recency[i - 1];
        recency[0] = moved;
    endfunction

    function automatic slot_result_t lookup_and_update(input logic [BIN_W-1:0] request);
        slot_result_t             r;
        logic                     found;
        logic [SLOT_IDX_W-1:0]    slot;
        logic [TAG_WIDTH_DEF-1:0] tag;
        r     = '0;
        found = 1'b0;
        slot  = '0;
        tag   = request[TAG_WIDTH_DEF-1:0];
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && tag_valid[i] && stored_tag[i] == tag) begin
                found = 1'b1;
                slot  = SLOT_IDX_W'(i);
            end
        end
        if (found) begin
            r.hit = 1'b1;
            for (int i = 0; i < filled; i++) begin
                if (recency[i] == slot) begin
                    promote(i);
                    break;
                end
            end
        end
        else if (filled < SLOTS) begin
            slot              = SLOT_IDX_W'(filled);
            stored_tag[slot]  = tag;
            tag_valid[slot]   = 1'b1;
            recency[filled]   = slot;
            promote(filled);
            filled++;
        end
        else begin
            // store full: the least recently used slot is reused
            slot             = recency[SLOTS - 1];
            r.ev_valid       = 1'b1;
            r.ev_bin         = BIN_W'(stored_tag[slot]);
            stored_tag[slot] = tag;
            promote(SLOTS - 1);
        end
        r.slot = slot;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            for (int i = 0; i < SLOTS; i++)
            begin
                tag_valid[i] = 1'b0;
                stored_tag[i] = '0;
                recency[i] = '0;
            end
            filled         = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
            result_count   <= 0;
            hit_count      <= 0;
            eviction_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(lookup_and_update(requested_bin));
            if (out_valid && out_ready)
            begin
                got = '{hit, slot_index, evicted_valid, evicted_bin};
                result_count <= result_count + 1;
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("[%0t] result transfer with nothing expected: hit=%0b slot=%0d ev=%0b bin=%h",
                                 $realtime, got.hit, got.slot, got.ev_valid, got.ev_bin);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.hit) hit_count <= hit_count + 1;
                    if (want.ev_valid) eviction_count <= eviction_count + 1;
                    if (got.hit !== want.hit || got.slot !== want.slot
                        || got.ev_valid !== want.ev_valid || got.ev_bin !== want.ev_bin)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("[%0t] mismatch: expected hit=%0b slot=%0d ev=%0b bin=%h, got hit=%0b slot=%0d ev=%0b bin=%h",
                                     $realtime, want.hit, want.slot, want.ev_valid, want.ev_bin,
                                     got.hit, got.slot, got.ev_valid, got.ev_bin);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            pending_count <= expected_results.size();
        end
    end

endmodule

FILE: bench/testbench.sv
// top of the lru slot replacement testbench: clock, reset, request and result traffic, verdict
module testbench;
    import lru_pkg::*;

    localparam int RANDOM_ITEMS  = 1850;
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_AFTER    = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int POOL_MAX      = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [BIN_W-1:0]      requested_bin;
    logic                  out_valid;
    logic                  out_ready;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  evicted_valid;
    logic [BIN_W-1:0]      evicted_bin;

    int mismatch_count;
    int pending_count;
    int result_count;
    int hit_count;
    int eviction_count;

    int sent_count;
    int idle_cycles;
    bit sender_busy;

    logic [BIN_W-1:0] pool [POOL_MAX];
    logic [BIN_W-1:0] last_tag;

    lru_slot_replacement_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .requested_bin (requested_bin),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .slot_index    (slot_index),
        .evicted_valid (evicted_valid),
        .evicted_bin   (evicted_bin)
    );

    lru_replacement_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .requested_bin  (requested_bin),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .slot_index     (slot_index),
        .evicted_valid  (evicted_valid),
        .evicted_bin    (evicted_bin),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .result_count   (result_count),
        .hit_count      (hit_count),
        .eviction_count (eviction_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit busy);
        int roll;
        roll = $urandom_range(0, 99);
        if (busy || roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input logic [BIN_W-1:0] tag);
        int gap;
        in_valid      <= 1'b1;
        requested_bin <= tag;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
        last_tag = tag;
        @(negedge clk);
        gap = pick_gap(sender_busy);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic fill_pool(input int size);
        logic [BIN_W-1:0] base;
        base = BIN_W'($urandom);
        for (int j = 0; j < size; j++)
        begin
            case ($urandom_range(0, 3))
                0:       pool[j] = base ^ (BIN_W'(1) << $urandom_range(0, BIN_W - 1));
                1:       pool[j] = BIN_W'($urandom_range(0, 15));
                default: pool[j] = BIN_W'($urandom);
            endcase
        end
    endtask

    // request traffic
    initial
    begin
        int size;
        int burst;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        requested_bin = '0;
        sent_count    = 0;
        sender_busy   = 1'b0;
        last_tag      = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: fill from empty, repeats on the most recent entry, hits on older
        // entries, then evictions of the least recently used identifier
        send_request(16'h0000);
        send_request(16'h0000);
        send_request(16'hFFFF);
        send_request(16'hFFFF);
        send_request(16'h0000);
        send_request(16'hAAAA);
        send_request(16'h5555);
        send_request(16'h5555);
        send_request(16'h1234);
        send_request(16'hFFFF);
        send_request(16'h0000);
        send_request(16'h8000);
        send_request(16'h0001);
        send_request(16'h7FFF);
        send_request(16'h8000);
        send_request(16'hFFFE);
        send_request(16'h0001);
        send_request(16'h7FFF);
        send_request(16'h8000);
        send_request(16'hFFFE);
        send_request(16'hFFFE);

        // random working sets, so that hits, fills and evictions mix
        while (sent_count < 21 + RANDOM_ITEMS)
        begin
            sender_busy = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(3, 15);
                repeat (burst) send_request(BIN_W'($urandom));
            end
            else
            begin
                size = $urandom_range(1, POOL_MAX);
                fill_pool(size);
                burst = $urandom_range(10, 40);
                repeat (burst)
                begin
                    if ($urandom_range(0, 9) < 3)
                        send_request(last_tag);
                    else
                        send_request(pool[$urandom_range(0, size - 1)]);
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests sent, %0d results checked: %0d hits, %0d evictions, %0d fills",
                 sent_count, result_count, hit_count, eviction_count,
                 result_count - hit_count - eviction_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off to fill the pipe
    initial
    begin
        int gap;
        bit held;
        bit busy;
        out_ready = 1'b0;
        held      = 1'b0;
        busy      = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && result_count >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if ($urandom_range(0, 63) == 0)
                busy = ~busy;
            gap = pick_gap(busy);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d results still expected",
                     IDLE_LIMIT, pending_count);
            $display("Verification failed");
            $finish;
        end
    end

endmodule

FILE: lru_slot_replacement_unit.f
+incdir+src
src/lru_pkg.sv
src/lru_tag_store.sv
src/lru_order_list.sv
src/lru_slot_replacement_unit.sv
src/lru_checker.sv
bench/lru_replacement_checker.sv
bench/testbench.sv
